/* rtl/rrfo_pkg.sv */
// ----------------------------------------------------------------------------
// rrfo_pkg: shared types and constants of the rectangle rasterizer
// Command, status, shape and register codes, setup step codes, payload
// structs of both channels and the coverage flags between the units.
// ----------------------------------------------------------------------------
package rrfo_pkg;

   // Fixed field widths
   localparam int FIX_W      = 24;  // signed fixed-point coordinate fields
   localparam int POS_W      = 28;  // compare width, holds pixel positions and bounds
   localparam int CMP_W      = 11;  // canvas size compare width, holds up to 1024
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   // Commands
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_DRAW  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // Result status
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BADRECT = 2'd1;
   localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

   // Shape kind bytes
   localparam logic [7:0] KIND_OUTLINE = 8'd114;
   localparam logic [7:0] KIND_FILLED  = 8'd82;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKGROUND = 2'd2;

   // Bound setup steps, one add or subtract each
   localparam logic [2:0] STEP_RIGHT   = 3'd0;
   localparam logic [2:0] STEP_BOTTOM  = 3'd1;
   localparam logic [2:0] STEP_LEFT1   = 3'd2;
   localparam logic [2:0] STEP_TOP1    = 3'd3;
   localparam logic [2:0] STEP_RIGHT1  = 3'd4;
   localparam logic [2:0] STEP_BOTTOM1 = 3'd5;

   typedef struct packed {
      logic [1:0]              command;
      logic [7:0]              shape_kind;
      logic signed [FIX_W-1:0] left_x;
      logic signed [FIX_W-1:0] top_y;
      logic signed [FIX_W-1:0] rect_width;
      logic signed [FIX_W-1:0] rect_height;
      logic [7:0]              color;
      logic [7:0]              read_col;
      logic [7:0]              read_row;
   } req_type;

   typedef struct packed {
      logic [7:0] pixel_value;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic       en;
      logic [2:0] step;
   } setup_type;

   typedef struct packed {
      logic in_box;
      logic on_edge;
   } cover_type;

endpackage

/* rtl/rrfo_cover.sv */
// ----------------------------------------------------------------------------
// rrfo_cover: rectangle bounds and per-pixel coverage test
// One shared add/subtract unit builds the six rectangle bounds over six
// setup steps; the scan then tests one pixel per cycle against them.
// ----------------------------------------------------------------------------
module rrfo_cover #(
   parameter int FRAC_BITS = 8,
   parameter int COL_W     = 8,
   parameter int ROW_W     = 8
) (
   input  logic                              clock,
   input  rrfo_pkg::setup_type               setup,
   input  logic signed [rrfo_pkg::FIX_W-1:0] left_x,
   input  logic signed [rrfo_pkg::FIX_W-1:0] top_y,
   input  logic signed [rrfo_pkg::FIX_W-1:0] rect_width,
   input  logic signed [rrfo_pkg::FIX_W-1:0] rect_height,
   input  logic [COL_W-1:0]                  scan_col,
   input  logic [ROW_W-1:0]                  scan_row,
   output rrfo_pkg::cover_type               pix_cov
);

   localparam int PW = rrfo_pkg::POS_W;
   localparam logic signed [PW-1:0] ONE = PW'(1) << FRAC_BITS;

   logic signed [PW-1:0] left_pos, top_pos, x_pos, y_pos;
   logic signed [PW-1:0] add_a, add_b, add_sum;
   logic                 add_sub;
   logic signed [PW-1:0] right_ff, bottom_ff, left1_ff, top1_ff, right1_ff, bottom1_ff;

   assign left_pos = PW'(left_x);
   assign top_pos  = PW'(top_y);

   // Pixel position in fixed point
   assign x_pos = PW'(scan_col) << FRAC_BITS;
   assign y_pos = PW'(scan_row) << FRAC_BITS;

   // Shared adder operand selection
   always_comb begin
      add_a   = left_pos;
      add_b   = PW'(rect_width);
      add_sub = 1'b0;
      unique case (setup.step)
         rrfo_pkg::STEP_RIGHT: begin
            add_a = left_pos;
            add_b = PW'(rect_width);
         end
         rrfo_pkg::STEP_BOTTOM: begin
            add_a = top_pos;
            add_b = PW'(rect_height);
         end
         rrfo_pkg::STEP_LEFT1: begin
            add_a = left_pos;
            add_b = ONE;
         end
         rrfo_pkg::STEP_TOP1: begin
            add_a = top_pos;
            add_b = ONE;
         end
         rrfo_pkg::STEP_RIGHT1: begin
            add_a   = right_ff;
            add_b   = ONE;
            add_sub = 1'b1;
         end
         rrfo_pkg::STEP_BOTTOM1: begin
            add_a   = bottom_ff;
            add_b   = ONE;
            add_sub = 1'b1;
         end
         default: begin
            add_a   = left_pos;
            add_b   = PW'(rect_width);
            add_sub = 1'b0;
         end
      endcase
   end

   assign add_sum = add_sub ? (add_a - add_b) : (add_a + add_b);

   // Bound registers, one per step
   always_ff @(posedge clock) begin
      if (setup.en) begin
         unique case (setup.step)
            rrfo_pkg::STEP_RIGHT:   right_ff   <= add_sum;
            rrfo_pkg::STEP_BOTTOM:  bottom_ff  <= add_sum;
            rrfo_pkg::STEP_LEFT1:   left1_ff   <= add_sum;
            rrfo_pkg::STEP_TOP1:    top1_ff    <= add_sum;
            rrfo_pkg::STEP_RIGHT1:  right1_ff  <= add_sum;
            rrfo_pkg::STEP_BOTTOM1: bottom1_ff <= add_sum;
            default: ;
         endcase
      end
   end

   // Closed box test; edge means less than one unit from any side
   assign pix_cov.in_box  = (left_pos <= x_pos) && (x_pos <= right_ff) &&
                            (top_pos <= y_pos) && (y_pos <= bottom_ff);
   assign pix_cov.on_edge = pix_cov.in_box &&
                            ((x_pos < left1_ff) || (x_pos > right1_ff) ||
                             (y_pos < top1_ff) || (y_pos > bottom1_ff));

endmodule

/* rtl/rrfo_canvas.sv */
// ----------------------------------------------------------------------------
// rrfo_canvas: pixel byte store
// One write port and one read port, read data registered. Address is
// {row, column}. Contents are undefined until written.
// ----------------------------------------------------------------------------
module rrfo_canvas #(
   parameter int ADDR_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/rectangle_raster_fill_outline_core.sv */
// ----------------------------------------------------------------------------
// rectangle_raster_fill_outline_core: axis-aligned rectangle rasterizer
// Byte canvas with clear, rectangle draw (filled or outline) and pixel read.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command per transfer (valid/ready). rsp_* returns
//   exactly one result per command: pixel_value and status. csr_* writes
//   the canvas width, height and background byte; write only while idle.
//   req_ready is high only while the sequencer is idle; one command is
//   worked on at a time.
// Work per command (w, h = effective canvas width and height):
//   clear : scans every pixel, one pixel written per cycle by the scan counters
//   draw  : six setup steps on the shared adder, then the scan of every pixel
//   bad draw, unused command, read outside canvas : no scan, result only
//   read  : one registered canvas read
//   The scan has one canvas write port, so it writes one pixel a cycle.
// Reset: sequencer idle, no result pending, width and height 256,
//   background 32. The canvas is not cleared; read it only after a clear.
// Stall: a finished result waits in the output register; the next command
//   can be taken meanwhile, and its result waits until the old one leaves.
// ----------------------------------------------------------------------------
module rectangle_raster_fill_outline_core #(
   parameter int MAX_COLS  = 256,
   parameter int MAX_ROWS  = 256,
   parameter int FRAC_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  rrfo_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rrfo_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [rrfo_pkg::CSR_IDX_W-1:0]      csr_addr,
   input  logic [rrfo_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW    = rrfo_pkg::CMP_W;

   // Sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SETUP = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]                     state_ff, state_in;
   logic [2:0]                     step_ff, step_in;
   logic [COL_W-1:0]               scan_col_ff, scan_col_in;
   logic [ROW_W-1:0]               scan_row_ff, scan_row_in;
   logic [1:0]                     status_ff, status_in;
   rrfo_pkg::req_type              req_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   rrfo_pkg::rsp_type              rsp_data_ff, rsp_data_in;
   logic [rrfo_pkg::CSR_DATA_W-1:0] width_ff, height_ff;
   logic [7:0]                     background_ff;

   logic                           req_xfer, rsp_load;
   logic [CW-1:0]                  cols_raw, rows_raw, eff_cols, eff_rows;
   logic [CW-1:0]                  last_col, last_row;
   logic                           col_end, row_end;
   logic                           rect_ok, read_out;
   logic [CW-1:0]                  rd_col_ext, rd_row_ext;
   rrfo_pkg::setup_type            setup;
   rrfo_pkg::cover_type            pix_cov;
   logic                           canvas_we;
   logic [7:0]                     canvas_wdata;
   logic                           canvas_re;
   logic [7:0]                     canvas_rdata;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= rrfo_pkg::CSR_DATA_W'(256);
         height_ff     <= rrfo_pkg::CSR_DATA_W'(256);
         background_ff <= 8'd32;
      end else if (csr_we) begin
         unique case (csr_addr)
            rrfo_pkg::CSR_WIDTH:      width_ff      <= csr_wdata;
            rrfo_pkg::CSR_HEIGHT:     height_ff     <= csr_wdata;
            rrfo_pkg::CSR_BACKGROUND: background_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Effective canvas size: zero acts as one, clamp to the maximum
   assign cols_raw = CW'(width_ff);
   assign rows_raw = CW'(height_ff);
   assign eff_cols = (cols_raw == '0) ? CW'(1) :
                     (cols_raw > CW'(MAX_COLS)) ? CW'(MAX_COLS) : cols_raw;
   assign eff_rows = (rows_raw == '0) ? CW'(1) :
                     (rows_raw > CW'(MAX_ROWS)) ? CW'(MAX_ROWS) : rows_raw;
   assign last_col = eff_cols - CW'(1);
   assign last_row = eff_rows - CW'(1);
   assign col_end  = (CW'(scan_col_ff) == last_col);
   assign row_end  = (CW'(scan_row_ff) == last_row);

   // Command checks on the incoming transfer
   assign rect_ok = ((req_data.shape_kind == rrfo_pkg::KIND_OUTLINE) ||
                     (req_data.shape_kind == rrfo_pkg::KIND_FILLED)) &&
                    (req_data.rect_width > 24'sd0) && (req_data.rect_height > 24'sd0);
   assign rd_col_ext = CW'(req_data.read_col);
   assign rd_row_ext = CW'(req_data.read_row);
   assign read_out   = (rd_col_ext >= eff_cols) || (rd_row_ext >= eff_rows);

   // Command register
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         req_ff <= req_data;
      end
   end

   // Sequencer next state
   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      scan_col_in = scan_col_ff;
      scan_row_in = scan_row_ff;
      status_in   = status_ff;
      rsp_load    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               status_in = rrfo_pkg::STATUS_OK;
               unique case (req_data.command)
                  rrfo_pkg::CMD_CLEAR: state_in = ST_SCAN;
                  rrfo_pkg::CMD_DRAW: begin
                     if (rect_ok) begin
                        state_in = ST_SETUP;
                        step_in  = rrfo_pkg::STEP_RIGHT;
                     end else begin
                        state_in  = ST_DONE;
                        status_in = rrfo_pkg::STATUS_BADRECT;
                     end
                  end
                  rrfo_pkg::CMD_READ: begin
                     if (read_out) begin
                        state_in  = ST_DONE;
                        status_in = rrfo_pkg::STATUS_OUTSIDE;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_SETUP: begin
            if (step_ff == rrfo_pkg::STEP_BOTTOM1) begin
               state_in = ST_SCAN;
               step_in  = rrfo_pkg::STEP_RIGHT;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_SCAN: begin
            if (col_end) begin
               scan_col_in = '0;
               if (row_end) begin
                  scan_row_in = '0;
                  state_in    = ST_DONE;
               end else begin
                  scan_row_in = scan_row_ff + ROW_W'(1);
               end
            end else begin
               scan_col_in = scan_col_ff + COL_W'(1);
            end
         end
         ST_READ: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         step_ff     <= rrfo_pkg::STEP_RIGHT;
         scan_col_ff <= '0;
         scan_row_ff <= '0;
         status_ff   <= rrfo_pkg::STATUS_OK;
      end else begin
         state_ff    <= state_in;
         step_ff     <= step_in;
         scan_col_ff <= scan_col_in;
         scan_row_ff <= scan_row_in;
         status_ff   <= status_in;
      end
   end

   // Bounds and coverage unit
   assign setup.en   = (state_ff == ST_SETUP);
   assign setup.step = step_ff;

   rrfo_cover #(
      .FRAC_BITS (FRAC_BITS),
      .COL_W     (COL_W),
      .ROW_W     (ROW_W)
   ) u_cover (
      .clock       (clock),
      .setup       (setup),
      .left_x      (req_ff.left_x),
      .top_y       (req_ff.top_y),
      .rect_width  (req_ff.rect_width),
      .rect_height (req_ff.rect_height),
      .scan_col    (scan_col_ff),
      .scan_row    (scan_row_ff),
      .pix_cov     (pix_cov)
   );

   // Canvas write during the scan, read for a read command
   always_comb begin
      canvas_we    = 1'b0;
      canvas_wdata = req_ff.color;
      if (state_ff == ST_SCAN) begin
         if (req_ff.command == rrfo_pkg::CMD_CLEAR) begin
            canvas_we    = 1'b1;
            canvas_wdata = background_ff;
         end else if (req_ff.shape_kind == rrfo_pkg::KIND_FILLED) begin
            canvas_we = pix_cov.in_box;
         end else begin
            canvas_we = pix_cov.on_edge;
         end
      end
   end

   assign canvas_re = (state_ff == ST_READ);

   rrfo_canvas #(
      .ADDR_W (COL_W + ROW_W)
   ) u_canvas (
      .clock   (clock),
      .wr_en   (canvas_we),
      .wr_addr ({scan_row_ff, scan_col_ff}),
      .wr_data (canvas_wdata),
      .rd_en   (canvas_re),
      .rd_addr ({ROW_W'(req_ff.read_row), COL_W'(req_ff.read_col)}),
      .rd_data (canvas_rdata)
   );

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in       = 1'b1;
         rsp_data_in.status = status_ff;
         rsp_data_in.pixel_value =
            ((req_ff.command == rrfo_pkg::CMD_READ) && (status_ff == rrfo_pkg::STATUS_OK)) ?
            canvas_rdata : 8'd0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   a_write_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      canvas_we |-> (state_ff == ST_SCAN))
      else $error("canvas written outside the scan");

   a_scan_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_SCAN) |-> ((scan_col_ff == '0) && (scan_row_ff == '0)))
      else $error("scan counters not back at zero");

   a_error_pixel_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != rrfo_pkg::STATUS_OK)) |->
      (rsp_data.pixel_value == 8'd0))
      else $error("error result carries a pixel value");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_ready)
      else $error("command taken while the previous one is in progress");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwrites one not yet transferred");

endmodule

/* sim/tb_rectangle_raster_fill_outline_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rectangle_raster_fill_outline_core: self-checking bench of the rasterizer
// Commands go in through a queue-fed driver and results are checked by a
// monitor against an in-bench canvas model. The canvas is cleared in full
// first, then small canvases are used for directed and random commands, with
// random idle bursts on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_rectangle_raster_fill_outline_core;

   localparam int         CANVAS_COLS  = 256;
   localparam int         CANVAS_ROWS  = 256;
   localparam int         ONE_UNIT     = 256;        // 1.0 in Q15.8
   localparam int         LIMIT_CYCLES = 2_000_000;
   localparam int         LONG_HOLD    = 2000;
   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam logic [7:0] KIND_BAD     = 8'h55;

   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   rrfo_pkg::req_type               req_data  = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   rrfo_pkg::rsp_type               rsp_data;
   logic                            csr_we    = 1'b0;
   logic [rrfo_pkg::CSR_IDX_W-1:0]  csr_addr  = '0;
   logic [rrfo_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   rectangle_raster_fill_outline_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Canvas model and its register copies
   bit [7:0]                        canvas_model [0:CANVAS_COLS*CANVAS_ROWS-1];
   logic [rrfo_pkg::CSR_DATA_W-1:0] cfg_width  = 9'd256;
   logic [rrfo_pkg::CSR_DATA_W-1:0] cfg_height = 9'd256;
   logic [7:0]                      cfg_bg     = 8'd32;

   rrfo_pkg::req_type pending_cmds [$];
   rrfo_pkg::rsp_type expected_rsp [$];

   int mismatches  = 0;
   int cycle_count = 0;
   bit quiet_mode  = 1'b0;   // no idling on either side
   bit hold_req    = 1'b0;
   bit hold_done   = 1'b0;

   function automatic int eff_size(input logic [rrfo_pkg::CSR_DATA_W-1:0] v);
      if (v == 0)
         return 1;
      if (v > 256)
         return 256;
      return int'(v);
   endfunction

   // Paint the model canvas for one command and queue the result it gives
   function automatic void apply_command(input rrfo_pkg::req_type c);
      int                w, h, x, y;
      longint            l, t, rw, rh, px, py;
      bit                in_box, on_border;
      rrfo_pkg::rsp_type r;
      w = eff_size(cfg_width);
      h = eff_size(cfg_height);
      l  = {{40{c.left_x[23]}}, c.left_x};
      t  = {{40{c.top_y[23]}}, c.top_y};
      rw = {{40{c.rect_width[23]}}, c.rect_width};
      rh = {{40{c.rect_height[23]}}, c.rect_height};
      r.pixel_value = 8'd0;
      r.status      = rrfo_pkg::STATUS_OK;
      case (c.command)
         rrfo_pkg::CMD_CLEAR: begin
            for (y = 0; y < h; y++)
               for (x = 0; x < w; x++)
                  canvas_model[y*CANVAS_COLS + x] = cfg_bg;
         end
         rrfo_pkg::CMD_DRAW: begin
            if ((c.shape_kind != rrfo_pkg::KIND_OUTLINE &&
                 c.shape_kind != rrfo_pkg::KIND_FILLED) ||
                rw <= 0 || rh <= 0) begin
               r.status = rrfo_pkg::STATUS_BADRECT;
            end else begin
               for (y = 0; y < h; y++) begin
                  for (x = 0; x < w; x++) begin
                     px = longint'(x) * ONE_UNIT;
                     py = longint'(y) * ONE_UNIT;
                     in_box = (l <= px) && (px <= l + rw) && (t <= py) && (py <= t + rh);
                     on_border = (px - l < ONE_UNIT) || (l + rw - px < ONE_UNIT) ||
                                 (py - t < ONE_UNIT) || (t + rh - py < ONE_UNIT);
                     if (in_box && (c.shape_kind == rrfo_pkg::KIND_FILLED || on_border))
                        canvas_model[y*CANVAS_COLS + x] = c.color;
                  end
               end
            end
         end
         rrfo_pkg::CMD_READ: begin
            if (int'(c.read_col) >= w || int'(c.read_row) >= h)
               r.status = rrfo_pkg::STATUS_OUTSIDE;
            else
               r.pixel_value = canvas_model[int'(c.read_row)*CANVAS_COLS + int'(c.read_col)];
         end
         default: ;
      endcase
      expected_rsp.push_back(r);
   endfunction

   // Driver: offers queued commands, predicts each one on transfer
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready)
            apply_command(req_data);
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() != 0 && !quiet_mode &&
                         $urandom_range(0, 5) == 0) begin
               send_gap  <= $urandom_range(0, 6);
               req_valid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= pending_cmds.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result transfer and drives rsp_ready
   int                stall_left = 0;
   int                hold_left  = 0;
   rrfo_pkg::rsp_type want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
         hold_left  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               mismatches = mismatches + 1;
               $display("%0t unexpected result: pixel_value %0d status %0d",
                        $time, rsp_data.pixel_value, rsp_data.status);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.pixel_value !== want.pixel_value) begin
                  mismatches = mismatches + 1;
                  $display("%0t pixel_value mismatch: expected %0d, actual %0d",
                           $time, want.pixel_value, rsp_data.pixel_value);
               end
               if (rsp_data.status !== want.status) begin
                  mismatches = mismatches + 1;
                  $display("%0t status mismatch: expected %0d, actual %0d",
                           $time, want.status, rsp_data.status);
               end
            end
         end
         if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            rsp_ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
         end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 6);
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Command with every field random, for the fields a command ignores
   function automatic rrfo_pkg::req_type random_fields();
      rrfo_pkg::req_type c;
      c.command     = 2'($urandom);
      c.shape_kind  = 8'($urandom);
      c.left_x      = 24'($urandom);
      c.top_y       = 24'($urandom);
      c.rect_width  = 24'($urandom);
      c.rect_height = 24'($urandom);
      c.color       = 8'($urandom);
      c.read_col    = 8'($urandom);
      c.read_row    = 8'($urandom);
      return c;
   endfunction

   function automatic void push_cmd(input logic [1:0] cmd);
      rrfo_pkg::req_type c;
      c = random_fields();
      c.command = cmd;
      pending_cmds.push_back(c);
   endfunction

   function automatic void push_draw(input logic [7:0] kind,
                                     input logic [23:0] l, t, w, h,
                                     input logic [7:0] color);
      rrfo_pkg::req_type c;
      c = random_fields();
      c.command     = rrfo_pkg::CMD_DRAW;
      c.shape_kind  = kind;
      c.left_x      = l;
      c.top_y       = t;
      c.rect_width  = w;
      c.rect_height = h;
      c.color       = color;
      pending_cmds.push_back(c);
   endfunction

   function automatic void push_read(input logic [7:0] col, row);
      rrfo_pkg::req_type c;
      c = random_fields();
      c.command  = rrfo_pkg::CMD_READ;
      c.read_col = col;
      c.read_row = row;
      pending_cmds.push_back(c);
   endfunction

   // Random command shaped around the current canvas size
   function automatic rrfo_pkg::req_type rand_command();
      rrfo_pkg::req_type c;
      int                w, h, pick, lx, ty, sw, sh;
      w = eff_size(cfg_width);
      h = eff_size(cfg_height);
      c = random_fields();
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         c.command = rrfo_pkg::CMD_CLEAR;
      end else if (pick < 60) begin
         c.command    = rrfo_pkg::CMD_DRAW;
         c.shape_kind = $urandom_range(0, 1) ? rrfo_pkg::KIND_FILLED : rrfo_pkg::KIND_OUTLINE;
         if ($urandom_range(0, 2) == 0) begin
            // whole-unit corners and sizes hit the exact boundary compares
            lx = $urandom_range(0, w + 2);
            ty = $urandom_range(0, h + 2);
            lx = (lx - 1) * ONE_UNIT;
            ty = (ty - 1) * ONE_UNIT;
            sw = $urandom_range(1, w + 1) * ONE_UNIT;
            sh = $urandom_range(1, h + 1) * ONE_UNIT;
         end else begin
            lx = $urandom_range(0, (w + 4) * ONE_UNIT);
            ty = $urandom_range(0, (h + 4) * ONE_UNIT);
            lx = lx - 2 * ONE_UNIT;
            ty = ty - 2 * ONE_UNIT;
            sw = $urandom_range(1, (w + 2) * ONE_UNIT);
            sh = $urandom_range(1, (h + 2) * ONE_UNIT);
         end
         if ($urandom_range(0, 19) != 0) begin
            c.left_x      = lx[23:0];
            c.top_y       = ty[23:0];
            c.rect_width  = sw[23:0];
            c.rect_height = sh[23:0];
         end
         case ($urandom_range(0, 11))
            0: begin
               c.shape_kind = 8'($urandom);
               if (c.shape_kind == rrfo_pkg::KIND_FILLED ||
                   c.shape_kind == rrfo_pkg::KIND_OUTLINE)
                  c.shape_kind = KIND_BAD;
            end
            1: begin
               sw = $urandom_range(0, 24'h800000);
               sw = -sw;
               c.rect_width = sw[23:0];
            end
            2: begin
               sh = $urandom_range(0, 24'h800000);
               sh = -sh;
               c.rect_height = sh[23:0];
            end
            default: ;
         endcase
      end else if (pick < 95) begin
         c.command = rrfo_pkg::CMD_READ;
         if ($urandom_range(0, 5) != 0) begin
            c.read_col = 8'($urandom_range(0, w - 1));
            c.read_row = 8'($urandom_range(0, h - 1));
         end
      end else begin
         c.command = CMD_UNUSED;
      end
      return c;
   endfunction

   task automatic write_csr(input logic [rrfo_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rrfo_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         rrfo_pkg::CSR_WIDTH:      cfg_width  = val;
         rrfo_pkg::CSR_HEIGHT:     cfg_height = val;
         rrfo_pkg::CSR_BACKGROUND: cfg_bg     = val[7:0];
         default: ;
      endcase
   endtask

   task automatic set_canvas(input logic [rrfo_pkg::CSR_DATA_W-1:0] w, h,
                             input logic [7:0] bg);
      write_csr(rrfo_pkg::CSR_WIDTH, w);
      write_csr(rrfo_pkg::CSR_HEIGHT, h);
      write_csr(rrfo_pkg::CSR_BACKGROUND, {1'b0, bg});
      @(negedge clock);
   endtask

   // Block is idle once every queued command has produced its result
   task automatic wait_drained();
      while (pending_cmds.size() != 0 || req_valid || expected_rsp.size() != 0)
         @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   task automatic random_phase(input logic [rrfo_pkg::CSR_DATA_W-1:0] w, h,
                               input logic [7:0] bg, input int count);
      set_canvas(w, h, bg);
      repeat (count) pending_cmds.push_back(rand_command());
      wait_drained();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Full-size canvas at reset settings: one clear writes every pixel
      push_cmd(rrfo_pkg::CMD_CLEAR);
      push_read(8'd0, 8'd0);
      push_read(8'd255, 8'd255);
      push_draw(rrfo_pkg::KIND_OUTLINE, 24'h000A80, 24'h000500, 24'h003000, 24'h000280,
                8'hFF);
      push_read(8'd11, 8'd5);
      push_read(8'd30, 8'd6);
      wait_drained();

      // Small canvas: coordinate extremes, both kinds, bad rectangles
      set_canvas(9'd16, 9'd12, 8'h00);
      push_cmd(rrfo_pkg::CMD_CLEAR);
      push_draw(rrfo_pkg::KIND_FILLED, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF,
                8'h11);
      push_draw(rrfo_pkg::KIND_FILLED, 24'h000180, 24'h000040, 24'h000300, 24'h000200,
                8'hA5);
      push_read(8'd2, 8'd1);
      push_read(8'd1, 8'd1);
      push_draw(rrfo_pkg::KIND_OUTLINE, 24'h000400, 24'h000400, 24'h000100, 24'h000100,
                8'h3C);
      push_draw(rrfo_pkg::KIND_OUTLINE, 24'h000000, 24'h000000, 24'h000F00, 24'h000B00,
                8'h7E);
      push_read(8'd5, 8'd5);
      push_read(8'd15, 8'd11);
      push_draw(KIND_BAD, 24'h000100, 24'h000100, 24'h000200, 24'h000200, 8'hEE);
      push_draw(rrfo_pkg::KIND_FILLED, 24'h000100, 24'h000100, 24'h000000, 24'h000200,
                8'hEE);
      push_draw(rrfo_pkg::KIND_OUTLINE, 24'h000100, 24'h000100, 24'h000200, 24'hFFFF00,
                8'hEE);
      push_draw(rrfo_pkg::KIND_FILLED, 24'h000100, 24'h000100, 24'h800000, 24'h000200,
                8'hEE);
      push_read(8'd16, 8'd0);
      push_read(8'd0, 8'd12);
      push_cmd(CMD_UNUSED);
      push_draw(rrfo_pkg::KIND_OUTLINE, 24'hFFFF80, 24'hC00000, 24'h7FFFFF, 24'h7FFFFF,
                8'hC3);
      push_read(8'd0, 8'd3);
      push_read(8'd1, 8'd3);
      wait_drained();

      // Random commands over a range of canvas settings
      random_phase(9'd1, 9'd1, 8'hFF, 9);
      random_phase(9'd0, 9'd6, 8'h00, 9);
      random_phase(9'd511, 9'd1, 8'h5A, 9);
      random_phase(9'd9, 9'd0, 8'($urandom), 9);
      random_phase(9'd6, 9'd300, 8'($urandom), 9);
      hold_req = 1'b1;
      random_phase(9'd20, 9'd15, 8'($urandom), 10);
      random_phase(9'd33, 9'd9, 8'($urandom), 9);
      quiet_mode = 1'b1;
      random_phase(9'd12, 9'd12, 8'($urandom), 10);

      repeat (20) @(negedge clock);
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

/* filelist.f */
rtl/rrfo_pkg.sv
rtl/rrfo_cover.sv
rtl/rrfo_canvas.sv
rtl/rectangle_raster_fill_outline_core.sv
sim/tb_rectangle_raster_fill_outline_core.sv
